// ===== design/kdj_pkg.sv =====
// ----------------------------------------------------------------------------
// KDJ oscillator package
// Shared constants, operation codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package kdj_pkg;

    localparam int MAX_WINDOW = 64;
    localparam int PRICE_BITS = 32;
    localparam int CFG_W      = 7;
    localparam int IDX_W      = 2;
    localparam int KD_W       = 23;
    localparam int J_W        = 26;
    localparam int SLOT_W     = $clog2(MAX_WINDOW);
    localparam int CNT_W      = $clog2(MAX_WINDOW + 1);
    localparam int MUL_A_W    = (PRICE_BITS > KD_W) ? PRICE_BITS : KD_W;
    localparam int PROD_W     = MUL_A_W + KD_W;
    localparam int QCNT_W     = $clog2(KD_W + 1);
    localparam int IN_DATA_W  = ((3 * PRICE_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((2 * KD_W + J_W + 7) / 8) * 8;

    localparam logic [KD_W-1:0] RSV_FULL = KD_W'(6553600);
    localparam logic [KD_W-1:0] RSV_HALF = KD_W'(3276800);

    localparam logic [IDX_W-1:0] REG_WINDOW_LENGTH = 2'd0;
    localparam logic [IDX_W-1:0] REG_K_SMOOTHING   = 2'd1;
    localparam logic [IDX_W-1:0] REG_D_SMOOTHING   = 2'd2;

    localparam logic [CFG_W-1:0] WINDOW_LENGTH_RST = 7'd9;
    localparam logic [CFG_W-1:0] K_SMOOTHING_RST   = 7'd3;
    localparam logic [CFG_W-1:0] D_SMOOTHING_RST   = 7'd3;

    typedef logic [PRICE_BITS-1:0] price_t;
    typedef logic [KD_W-1:0]       kd_t;

    typedef enum logic [1:0] {
        OP_RSV,
        OP_K,
        OP_D
    } op_t;

    typedef struct packed {
        logic [CNT_W-1:0] win;
        logic [CFG_W-1:0] kdiv;
        logic [CFG_W-1:0] ddiv;
    } cfg_t;

    typedef struct packed {
        logic load;
        logic scan;
        logic eval;
        logic mul;
        logic div_load;
        logic div_step;
        logic rsv_take;
        logic rsv_apply;
        logic k_take;
        logic d_take;
        logic out_load;
        logic finish;
        op_t  op;
    } cmd_t;

    typedef struct packed {
        logic scan_done;
        logic need_div;
        logic seed;
        logic emit;
        logic div_done;
        logic out_free;
    } sts_t;

endpackage

// ===== design/kdj_stochastic_oscillator_unit.sv =====
// ----------------------------------------------------------------------------
// KDJ stochastic oscillator unit
// Takes price bars, tracks the high/low window and emits K, D and J lines.
// An emitting bar scans its window, then takes a pass of the shared 23-step
// divider for RSV (skipped when RSV clips or the window is flat), for K and
// for D before its result loads. One bar is in flight at a time; the next bar
// is accepted in the cycle after the result loads, and a waiting result stalls
// only the next emitting bar. The seed bar stops after RSV, earlier bars after
// evaluation.
// Reset clears control state and series state; configuration returns to 9/3/3.
// ----------------------------------------------------------------------------
module kdj_stochastic_oscillator_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    // s_tdata: bar_high, bar_low, bar_close
    input  logic [kdj_pkg::IN_DATA_W-1:0]     s_tdata,
    // s_tuser: first_bar
    input  logic                              s_tuser,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // m_tdata: k_line, d_line, j_line
    output logic [kdj_pkg::OUT_DATA_W-1:0]    m_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [kdj_pkg::IDX_W-1:0]         cfg_index,
    input  logic [kdj_pkg::CFG_W-1:0]         cfg_data
);

    logic [kdj_pkg::CFG_W-1:0] window_length_reg, window_length_next;
    logic [kdj_pkg::CFG_W-1:0] k_smoothing_reg, k_smoothing_next;
    logic [kdj_pkg::CFG_W-1:0] d_smoothing_reg, d_smoothing_next;
    kdj_pkg::cfg_t             cfg;
    kdj_pkg::cmd_t             cmd;
    kdj_pkg::sts_t             sts;

    assign cfg_ready = 1'b1;

    always_comb begin
        window_length_next = window_length_reg;
        k_smoothing_next   = k_smoothing_reg;
        d_smoothing_next   = d_smoothing_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                kdj_pkg::REG_WINDOW_LENGTH: window_length_next = cfg_data;
                kdj_pkg::REG_K_SMOOTHING:   k_smoothing_next   = cfg_data;
                kdj_pkg::REG_D_SMOOTHING:   d_smoothing_next   = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_length_reg <= kdj_pkg::WINDOW_LENGTH_RST;
            k_smoothing_reg   <= kdj_pkg::K_SMOOTHING_RST;
            d_smoothing_reg   <= kdj_pkg::D_SMOOTHING_RST;
        end else begin
            window_length_reg <= window_length_next;
            k_smoothing_reg   <= k_smoothing_next;
            d_smoothing_reg   <= d_smoothing_next;
        end
    end

    // zero acts as one, window capped at memory depth
    always_comb begin
        if (window_length_reg == '0) begin
            cfg.win = kdj_pkg::CNT_W'(1);
        end else if (int'(window_length_reg) > kdj_pkg::MAX_WINDOW) begin
            cfg.win = kdj_pkg::CNT_W'(kdj_pkg::MAX_WINDOW);
        end else begin
            cfg.win = kdj_pkg::CNT_W'(window_length_reg);
        end
        cfg.kdiv = (k_smoothing_reg == '0) ? kdj_pkg::CFG_W'(1) : k_smoothing_reg;
        cfg.ddiv = (d_smoothing_reg == '0) ? kdj_pkg::CFG_W'(1) : d_smoothing_reg;
    end

    kdj_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    kdj_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .cfg      (cfg),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .sts      (sts),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// ===== design/kdj_datapath.sv =====
// ----------------------------------------------------------------------------
// KDJ datapath
// Bar window memory, min/max scan, shared multiplier and serial divider,
// RSV/K/D state and the result register.
// ----------------------------------------------------------------------------
module kdj_datapath (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  kdj_pkg::cmd_t                     cmd,
    input  kdj_pkg::cfg_t                     cfg,
    input  logic [kdj_pkg::IN_DATA_W-1:0]     s_tdata,
    input  logic                              s_tuser,
    output kdj_pkg::sts_t                     sts,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [kdj_pkg::OUT_DATA_W-1:0]    m_tdata
);

    localparam int P = kdj_pkg::PRICE_BITS;

    // window memory: {high, low}
    logic [2*P-1:0] win_mem [kdj_pkg::MAX_WINDOW];
    logic [2*P-1:0] mem_q_reg;

    logic [kdj_pkg::SLOT_W-1:0] write_slot_reg, write_slot_next;
    logic [kdj_pkg::CNT_W-1:0]  bars_seen_reg, bars_seen_next;
    logic [kdj_pkg::CNT_W-1:0]  scan_k_reg, scan_k_next;
    logic                       rd_vld_reg, rd_vld_next;
    kdj_pkg::kd_t               k_reg, k_next;
    kdj_pkg::kd_t               d_reg, d_next;
    kdj_pkg::kd_t               rsv_cur_reg, rsv_cur_next;
    kdj_pkg::kd_t               rsv_prev_reg, rsv_prev_next;
    logic                       m_tvalid_reg, m_tvalid_next;

    kdj_pkg::price_t            mx_reg, mx_next;
    kdj_pkg::price_t            mn_reg, mn_next;
    kdj_pkg::price_t            close_reg, close_next;
    logic                       flat_reg, flat_next;
    kdj_pkg::kd_t               rsv_reg, rsv_next;
    logic [kdj_pkg::PROD_W-1:0] prod_reg, prod_next;
    logic [kdj_pkg::MUL_A_W-1:0] rem_reg, rem_next;
    kdj_pkg::kd_t               lo_reg, lo_next;
    kdj_pkg::kd_t               quo_reg, quo_next;
    logic [kdj_pkg::MUL_A_W-1:0] divisor_reg, divisor_next;
    logic [kdj_pkg::QCNT_W-1:0] div_cnt_reg, div_cnt_next;
    kdj_pkg::kd_t               out_k_reg, out_k_next;
    kdj_pkg::kd_t               out_d_reg, out_d_next;
    logic [kdj_pkg::J_W-1:0]    out_j_reg, out_j_next;

    kdj_pkg::price_t             s_high, s_low, s_close;
    logic [kdj_pkg::CNT_W:0]     idx_inc;
    logic                        do_scan;
    logic [kdj_pkg::CNT_W-1:0]   scan_lim;
    logic                        scan_issue;
    logic [kdj_pkg::SLOT_W:0]    addr_sum;
    logic [kdj_pkg::SLOT_W-1:0]  rd_addr;
    kdj_pkg::price_t             q_high, q_low;
    logic                        flat_now;
    logic [kdj_pkg::MUL_A_W-1:0] mul_a;
    kdj_pkg::kd_t                mul_b;
    kdj_pkg::kd_t                addend;
    logic [kdj_pkg::MUL_A_W-1:0] div_sel;
    logic [kdj_pkg::PROD_W-1:0]  num;
    logic [kdj_pkg::MUL_A_W:0]   trial;
    logic                        trial_ge;
    logic [kdj_pkg::MUL_A_W:0]   trial_sub;
    kdj_pkg::kd_t                seed_val;

    assign s_high  = s_tdata[P-1:0];
    assign s_low   = s_tdata[2*P-1:P];
    assign s_close = s_tdata[3*P-1:2*P];

    assign idx_inc  = {1'b0, bars_seen_reg} + 1'b1;
    assign do_scan  = idx_inc >= {1'b0, cfg.win};
    assign scan_lim = do_scan ? cfg.win : kdj_pkg::CNT_W'(1);

    assign scan_issue = cmd.scan && (scan_k_reg < scan_lim);

    always_comb begin
        addr_sum = (kdj_pkg::SLOT_W+1)'(write_slot_reg)
                 + (kdj_pkg::SLOT_W+1)'(kdj_pkg::MAX_WINDOW)
                 - (kdj_pkg::SLOT_W+1)'(scan_k_reg);
        if (addr_sum >= (kdj_pkg::SLOT_W+1)'(kdj_pkg::MAX_WINDOW)) begin
            addr_sum = addr_sum - (kdj_pkg::SLOT_W+1)'(kdj_pkg::MAX_WINDOW);
        end
        rd_addr = addr_sum[kdj_pkg::SLOT_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            win_mem[write_slot_reg] <= {s_high, s_low};
        end
        mem_q_reg <= win_mem[rd_addr];
    end

    assign q_high   = mem_q_reg[2*P-1:P];
    assign q_low    = mem_q_reg[P-1:0];
    assign flat_now = mx_reg <= mn_reg;

    // shared multiplier operands
    always_comb begin
        unique case (cmd.op)
            kdj_pkg::OP_RSV: begin
                mul_a   = kdj_pkg::MUL_A_W'(close_reg - mn_reg);
                mul_b   = kdj_pkg::RSV_FULL;
                addend  = '0;
                div_sel = kdj_pkg::MUL_A_W'(mx_reg - mn_reg);
            end
            kdj_pkg::OP_K: begin
                mul_a   = kdj_pkg::MUL_A_W'(k_reg);
                mul_b   = kdj_pkg::KD_W'(cfg.kdiv - 1'b1);
                addend  = rsv_cur_reg;
                div_sel = kdj_pkg::MUL_A_W'(cfg.kdiv);
            end
            kdj_pkg::OP_D: begin
                mul_a   = kdj_pkg::MUL_A_W'(d_reg);
                mul_b   = kdj_pkg::KD_W'(cfg.ddiv - 1'b1);
                addend  = k_reg;
                div_sel = kdj_pkg::MUL_A_W'(cfg.ddiv);
            end
            default: begin
                mul_a   = '0;
                mul_b   = '0;
                addend  = '0;
                div_sel = kdj_pkg::MUL_A_W'(1);
            end
        endcase
    end

    assign num       = prod_reg + kdj_pkg::PROD_W'(addend);
    assign trial     = {rem_reg, lo_reg[kdj_pkg::KD_W-1]};
    assign trial_ge  = trial >= {1'b0, divisor_reg};
    assign trial_sub = trial - {1'b0, divisor_reg};
    assign seed_val  = flat_reg ? kdj_pkg::RSV_HALF : rsv_reg;

    always_comb begin
        write_slot_next = write_slot_reg;
        bars_seen_next  = bars_seen_reg;
        scan_k_next     = scan_k_reg;
        rd_vld_next     = scan_issue;
        k_next          = k_reg;
        d_next          = d_reg;
        rsv_cur_next    = rsv_cur_reg;
        rsv_prev_next   = rsv_prev_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        mx_next         = mx_reg;
        mn_next         = mn_reg;
        close_next      = close_reg;
        flat_next       = flat_reg;
        rsv_next        = rsv_reg;
        prod_next       = prod_reg;
        rem_next        = rem_reg;
        lo_next         = lo_reg;
        quo_next        = quo_reg;
        divisor_next    = divisor_reg;
        div_cnt_next    = div_cnt_reg;
        out_k_next      = out_k_reg;
        out_d_next      = out_d_reg;
        out_j_next      = out_j_reg;

        if (cmd.load) begin
            mx_next     = s_high;
            mn_next     = s_low;
            close_next  = s_close;
            scan_k_next = kdj_pkg::CNT_W'(1);
            if (s_tuser) begin
                bars_seen_next = '0;
                k_next         = '0;
                d_next         = '0;
                rsv_cur_next   = '0;
                rsv_prev_next  = '0;
            end
        end

        if (scan_issue) begin
            scan_k_next = scan_k_reg + 1'b1;
        end
        if (rd_vld_reg) begin
            if (q_high > mx_reg) mx_next = q_high;
            if (q_low < mn_reg)  mn_next = q_low;
        end

        if (cmd.eval) begin
            flat_next = flat_now;
            if (!flat_now && close_reg >= mx_reg) begin
                rsv_next = kdj_pkg::RSV_FULL;
            end else begin
                rsv_next = '0;
            end
        end

        if (cmd.mul) begin
            prod_next = kdj_pkg::PROD_W'(mul_a * mul_b);
        end

        if (cmd.div_load) begin
            rem_next     = num[kdj_pkg::PROD_W-1:kdj_pkg::KD_W];
            lo_next      = num[kdj_pkg::KD_W-1:0];
            divisor_next = div_sel;
            quo_next     = '0;
            div_cnt_next = kdj_pkg::QCNT_W'(kdj_pkg::KD_W);
        end else if (cmd.div_step) begin
            rem_next     = trial_ge ? trial_sub[kdj_pkg::MUL_A_W-1:0]
                                    : trial[kdj_pkg::MUL_A_W-1:0];
            lo_next      = {lo_reg[kdj_pkg::KD_W-2:0], 1'b0};
            quo_next     = {quo_reg[kdj_pkg::KD_W-2:0], trial_ge};
            div_cnt_next = div_cnt_reg - 1'b1;
        end

        if (cmd.rsv_take) begin
            rsv_next = quo_reg;
        end

        if (cmd.rsv_apply) begin
            if (sts.seed) begin
                rsv_cur_next  = seed_val;
                rsv_prev_next = seed_val;
            end else if (flat_reg) begin
                rsv_cur_next  = rsv_prev_reg;
            end else begin
                rsv_prev_next = rsv_cur_reg;
                rsv_cur_next  = rsv_reg;
            end
        end

        if (cmd.k_take) begin
            k_next = quo_reg;
        end
        if (cmd.d_take) begin
            d_next = quo_reg;
        end

        if (cmd.out_load) begin
            m_tvalid_next = 1'b1;
            out_k_next    = k_reg;
            out_d_next    = d_reg;
            out_j_next    = kdj_pkg::J_W'({k_reg, 1'b0}) + kdj_pkg::J_W'(k_reg)
                          - kdj_pkg::J_W'({d_reg, 1'b0});
        end

        if (cmd.finish) begin
            if (write_slot_reg == kdj_pkg::SLOT_W'(kdj_pkg::MAX_WINDOW - 1)) begin
                write_slot_next = '0;
            end else begin
                write_slot_next = write_slot_reg + 1'b1;
            end
            if (bars_seen_reg < kdj_pkg::CNT_W'(kdj_pkg::MAX_WINDOW)) begin
                bars_seen_next = bars_seen_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            write_slot_reg <= '0;
            bars_seen_reg  <= '0;
            scan_k_reg     <= kdj_pkg::CNT_W'(1);
            rd_vld_reg     <= 1'b0;
            k_reg          <= '0;
            d_reg          <= '0;
            rsv_cur_reg    <= '0;
            rsv_prev_reg   <= '0;
            m_tvalid_reg   <= 1'b0;
            div_cnt_reg    <= '0;
        end else begin
            write_slot_reg <= write_slot_next;
            bars_seen_reg  <= bars_seen_next;
            scan_k_reg     <= scan_k_next;
            rd_vld_reg     <= rd_vld_next;
            k_reg          <= k_next;
            d_reg          <= d_next;
            rsv_cur_reg    <= rsv_cur_next;
            rsv_prev_reg   <= rsv_prev_next;
            m_tvalid_reg   <= m_tvalid_next;
            div_cnt_reg    <= div_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        mx_reg      <= mx_next;
        mn_reg      <= mn_next;
        close_reg   <= close_next;
        flat_reg    <= flat_next;
        rsv_reg     <= rsv_next;
        prod_reg    <= prod_next;
        rem_reg     <= rem_next;
        lo_reg      <= lo_next;
        quo_reg     <= quo_next;
        divisor_reg <= divisor_next;
        out_k_reg   <= out_k_next;
        out_d_reg   <= out_d_next;
        out_j_reg   <= out_j_next;
    end

    always_comb begin
        sts.scan_done = !rd_vld_reg && (scan_k_reg >= scan_lim);
        sts.need_div  = !flat_now && (close_reg > mn_reg) && (close_reg < mx_reg);
        sts.seed      = idx_inc == {1'b0, cfg.win};
        sts.emit      = bars_seen_reg >= cfg.win;
        sts.div_done  = div_cnt_reg == '0;
        sts.out_free  = !m_tvalid_reg || m_tready;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = kdj_pkg::OUT_DATA_W'({out_j_reg, out_d_reg, out_k_reg});

    a_div_step_live: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_step |-> div_cnt_reg != '0)
        else $error("divider stepped after completion");

    a_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_tvalid_reg || m_tready))
        else $error("result register overwritten before transfer");

    a_quo_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.rsv_take || cmd.k_take || cmd.d_take) |-> quo_reg <= kdj_pkg::RSV_FULL)
        else $error("quotient above full scale");

    a_rd_origin: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_vld_reg |-> $past(cmd.scan))
        else $error("window read without scan command");

endmodule

// ===== design/kdj_ctrl.sv =====
// ----------------------------------------------------------------------------
// KDJ controller
// Sequences load, window scan, RSV scaling, K and D updates and result hand-off.
// ----------------------------------------------------------------------------
module kdj_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  kdj_pkg::sts_t sts,
    output kdj_pkg::cmd_t cmd
);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_SCAN    = 4'd1;
    localparam logic [3:0] S_EVAL    = 4'd2;
    localparam logic [3:0] S_RMUL    = 4'd3;
    localparam logic [3:0] S_RDIV_LD = 4'd4;
    localparam logic [3:0] S_RDIV    = 4'd5;
    localparam logic [3:0] S_RSV     = 4'd6;
    localparam logic [3:0] S_KMUL    = 4'd7;
    localparam logic [3:0] S_KDIV_LD = 4'd8;
    localparam logic [3:0] S_KDIV    = 4'd9;
    localparam logic [3:0] S_DMUL    = 4'd10;
    localparam logic [3:0] S_DDIV_LD = 4'd11;
    localparam logic [3:0] S_DDIV    = 4'd12;
    localparam logic [3:0] S_OUT     = 4'd13;
    localparam logic [3:0] S_FIN     = 4'd14;

    logic [3:0] state_reg, state_next;

    assign s_tready = state_reg == S_IDLE;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.op     = kdj_pkg::OP_RSV;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                cmd.scan = 1'b1;
                if (sts.scan_done) state_next = S_EVAL;
            end
            S_EVAL: begin
                cmd.eval = 1'b1;
                if (!sts.seed && !sts.emit) begin
                    state_next = S_FIN;
                end else if (sts.need_div) begin
                    state_next = S_RMUL;
                end else begin
                    state_next = S_RSV;
                end
            end
            S_RMUL: begin
                cmd.mul    = 1'b1;
                cmd.op     = kdj_pkg::OP_RSV;
                state_next = S_RDIV_LD;
            end
            S_RDIV_LD: begin
                cmd.div_load = 1'b1;
                cmd.op       = kdj_pkg::OP_RSV;
                state_next   = S_RDIV;
            end
            S_RDIV: begin
                if (sts.div_done) begin
                    cmd.rsv_take = 1'b1;
                    state_next   = S_RSV;
                end else begin
                    cmd.div_step = 1'b1;
                end
            end
            S_RSV: begin
                cmd.rsv_apply = 1'b1;
                state_next    = sts.seed ? S_FIN : S_KMUL;
            end
            S_KMUL: begin
                cmd.mul    = 1'b1;
                cmd.op     = kdj_pkg::OP_K;
                state_next = S_KDIV_LD;
            end
            S_KDIV_LD: begin
                cmd.div_load = 1'b1;
                cmd.op       = kdj_pkg::OP_K;
                state_next   = S_KDIV;
            end
            S_KDIV: begin
                if (sts.div_done) begin
                    cmd.k_take = 1'b1;
                    state_next = S_DMUL;
                end else begin
                    cmd.div_step = 1'b1;
                end
            end
            S_DMUL: begin
                cmd.mul    = 1'b1;
                cmd.op     = kdj_pkg::OP_D;
                state_next = S_DDIV_LD;
            end
            S_DDIV_LD: begin
                cmd.div_load = 1'b1;
                cmd.op       = kdj_pkg::OP_D;
                state_next   = S_DDIV;
            end
            S_DDIV: begin
                if (sts.div_done) begin
                    cmd.d_take = 1'b1;
                    state_next = S_OUT;
                end else begin
                    cmd.div_step = 1'b1;
                end
            end
            S_OUT: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.finish   = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_FIN: begin
                cmd.finish = 1'b1;
                state_next = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule
